// ----- design/tcgp_pkg.sv -----
// tcgp_pkg: shared constants, codes and types of the table cell grid placer.
// No dependencies; imported by every module of the block but tcgp_ram.
`default_nettype none

package tcgp_pkg;

	// defaults for the top-level parameters
	localparam int MAX_COLUMNS_DEF = 32;
	localparam int ROW_WINDOW_DEF  = 16;

	// fixed field widths of the item and result beats
	localparam int OPCODE_W   = 1;
	localparam int CSPAN_W    = 6;
	localparam int RSPAN_W    = 8;
	localparam int COLIDX_W   = 5;
	localparam int ROWIDX_W   = 16;
	localparam int COLCNT_W   = 6;
	localparam int INHERIT_W  = 32;
	localparam int STATUS_W   = 2;

	localparam logic [ROWIDX_W-1:0] ROW_INDEX_MAX = '1;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_START_ROW = 1'b0;
	localparam logic [OPCODE_W-1:0] OP_PLACE     = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_ROOM = 2'd1;
	localparam logic [STATUS_W-1:0] ST_CLAMPED = 2'd2;

	// flags from the run test unit
	typedef struct packed {
		logic fits;  // the run ends at or before the last column
		logic free;  // no column of the run is taken
	} run_flags_t;

endpackage

`default_nettype wire

// ----- design/tcgp_ram.sv -----
// tcgp_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tcgp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- design/tcgp_run_unit.sv -----
// tcgp_run_unit: shared shift-and-compare unit that tests one candidate run.
// Depends on tcgp_pkg for the flag struct and field widths.
`default_nettype none

module tcgp_run_unit
	import tcgp_pkg::*;
#(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
	input  wire logic [MAX_COLUMNS-1:0]         cur,
	input  wire logic [MAX_COLUMNS-1:0]         span_mask,
	input  wire logic [$clog2(MAX_COLUMNS+1)-1:0] start,
	input  wire logic [CSPAN_W-1:0]             span,
	output logic      [MAX_COLUMNS-1:0]         run,
	output logic      [$clog2(MAX_COLUMNS+1)-1:0] run_end,
	output run_flags_t                          flags
);

	localparam int CW = $clog2(MAX_COLUMNS + 1);
	localparam int XW = ((CW > CSPAN_W) ? CW : CSPAN_W) + 1;

	logic [XW-1:0] end_sum;

	always_comb begin
		end_sum    = XW'(start) + XW'(span);
		run        = span_mask << start;
		run_end    = end_sum[CW-1:0];
		flags.fits = (end_sum <= XW'(MAX_COLUMNS));
		flags.free = ((cur & run) == '0);
	end

endmodule

`default_nettype wire

// ----- design/tcgp_ctrl.sv -----
// tcgp_ctrl: sequencer, grid state and result register of the placer.
// Depends on tcgp_pkg, tcgp_ram and tcgp_run_unit.
`default_nettype none

module tcgp_ctrl
	import tcgp_pkg::*;
#(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int ROW_WINDOW  = ROW_WINDOW_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [OPCODE_W-1:0]  opcode,
	input  wire logic [CSPAN_W-1:0]   column_span,
	input  wire logic [RSPAN_W-1:0]   row_span,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [COLIDX_W-1:0]  column_index,
	output logic      [ROWIDX_W-1:0]  row_index,
	output logic      [COLCNT_W-1:0]  column_count,
	output logic      [INHERIT_W-1:0] inherited_columns,
	output logic      [STATUS_W-1:0]  status
);

	localparam int CW  = $clog2(MAX_COLUMNS + 1);
	localparam int HW  = $clog2(ROW_WINDOW);
	localparam int RCW = $clog2(ROW_WINDOW + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_INH   = 3'd1;
	localparam logic [2:0] S_LOAD  = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_MARK  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	function automatic logic [HW-1:0] slot_inc(input logic [HW-1:0] a);
		return (a == HW'(ROW_WINDOW - 1)) ? '0 : a + 1'b1;
	endfunction

	logic [2:0]             state_q;
	logic [HW-1:0]          head_q;
	logic [CW-1:0]          cursor_q;
	logic [CW-1:0]          widest_q;
	logic [ROWIDX_W-1:0]    row_q;
	logic                   started_q;
	logic [ROW_WINDOW-1:0]  valid_q;

	logic [MAX_COLUMNS-1:0] cur_q;
	logic [MAX_COLUMNS-1:0] mask_q;
	logic [MAX_COLUMNS-1:0] run_q;
	logic [CSPAN_W-1:0]     span_q;
	logic [CW-1:0]          start_q;
	logic [RCW-1:0]         rows_q;
	logic                   clamp_q;
	logic                   found_q;
	logic [STATUS_W-1:0]    status_q;
	logic [MAX_COLUMNS-1:0] inh_q;

	logic [HW-1:0]          mk_addr_q;
	logic [HW-1:0]          wr_addr_q;
	logic                   pend_q;
	logic                   rvalid_q;

	logic                   out_valid_q;
	logic [COLIDX_W-1:0]    col_out_q;
	logic [ROWIDX_W-1:0]    row_out_q;
	logic [COLCNT_W-1:0]    cnt_out_q;
	logic [INHERIT_W-1:0]   inh_out_q;
	logic [STATUS_W-1:0]    st_out_q;

	logic                   accept;
	logic                   push;
	logic                   ram_we;
	logic                   ram_re;
	logic [HW-1:0]          ram_waddr;
	logic [HW-1:0]          ram_raddr;
	logic [MAX_COLUMNS-1:0] ram_wdata;
	logic [MAX_COLUMNS-1:0] ram_rdata;
	logic [MAX_COLUMNS-1:0] rd_eff;
	logic [MAX_COLUMNS-1:0] unit_run;
	logic [CW-1:0]          unit_end;
	run_flags_t             unit_flags;
	logic [CSPAN_W-1:0]     span_in;
	logic [RSPAN_W-1:0]     rows_in;
	logic                   clamp_in;
	logic [63:0]            start_ext;
	logic [63:0]            widest_ext;
	logic [63:0]            inh_ext;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign push      = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign rd_eff    = rvalid_q ? ram_rdata : '0;
	assign span_in   = (column_span == '0) ? CSPAN_W'(1) : column_span;
	assign rows_in   = (row_span == '0) ? RSPAN_W'(1) : row_span;
	assign clamp_in  = (rows_in > RSPAN_W'(ROW_WINDOW));

	assign start_ext  = 64'(start_q);
	assign widest_ext = 64'(widest_q);
	assign inh_ext    = 64'(inh_q);

	tcgp_ram #(
		.WIDTH(MAX_COLUMNS),
		.DEPTH(ROW_WINDOW)
	) u_window (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	tcgp_run_unit #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_run (
		.cur      (cur_q),
		.span_mask(mask_q),
		.start    (start_q),
		.span     (span_q),
		.run      (unit_run),
		.run_end  (unit_end),
		.flags    (unit_flags)
	);

	// window port control: one read and one write a cycle at most
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = head_q;
		ram_we    = 1'b0;
		ram_waddr = wr_addr_q;
		ram_wdata = rd_eff | run_q;
		if (accept) begin
			ram_re = 1'b1;
			if (opcode == OP_START_ROW && started_q) begin
				ram_raddr = slot_inc(head_q);
			end
		end else if (state_q == S_MARK) begin
			ram_re    = (rows_q != '0);
			ram_raddr = mk_addr_q;
			ram_we    = pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			cursor_q    <= '0;
			widest_q    <= '0;
			row_q       <= '0;
			started_q   <= 1'b0;
			valid_q     <= '0;
			pend_q      <= 1'b0;
			rvalid_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ram_re) begin
				rvalid_q <= valid_q[ram_raddr];
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						started_q <= 1'b1;
						if (opcode == OP_START_ROW) begin
							// retire the row left behind
							if (started_q) begin
								valid_q[head_q] <= 1'b0;
								head_q          <= slot_inc(head_q);
								if (row_q != ROW_INDEX_MAX) begin
									row_q <= row_q + 1'b1;
								end
							end
							cursor_q <= '0;
							state_q  <= S_INH;
						end else begin
							state_q <= S_LOAD;
						end
					end
				end
				S_INH: begin
					state_q <= S_DONE;
				end
				S_LOAD: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (!unit_flags.fits) begin
						state_q <= S_DONE;
					end else if (unit_flags.free) begin
						cursor_q <= unit_end;
						if (unit_end > widest_q) begin
							widest_q <= unit_end;
						end
						state_q <= S_MARK;
					end
				end
				S_MARK: begin
					if (rows_q != '0) begin
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (pend_q) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (push) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			found_q  <= 1'b0;
			inh_q    <= '0;
			start_q  <= cursor_q;
			span_q   <= span_in;
			mask_q   <= ~({MAX_COLUMNS{1'b1}} << span_in);
			clamp_q  <= clamp_in;
			rows_q   <= clamp_in ? RCW'(ROW_WINDOW) : RCW'(rows_in);
			status_q <= ST_OK;
		end
		case (state_q)
			S_INH: begin
				inh_q <= rd_eff;
			end
			S_LOAD: begin
				cur_q <= rd_eff;
			end
			S_SCAN: begin
				if (!unit_flags.fits) begin
					status_q <= ST_NO_ROOM;
				end else if (unit_flags.free) begin
					found_q   <= 1'b1;
					run_q     <= unit_run;
					mk_addr_q <= head_q;
					status_q  <= clamp_q ? ST_CLAMPED : ST_OK;
				end else begin
					start_q <= start_q + 1'b1;
				end
			end
			S_MARK: begin
				if (rows_q != '0) begin
					wr_addr_q <= mk_addr_q;
					mk_addr_q <= slot_inc(mk_addr_q);
					rows_q    <= rows_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (push) begin
			col_out_q <= found_q ? start_ext[COLIDX_W-1:0] : '0;
			row_out_q <= row_q;
			cnt_out_q <= widest_ext[COLCNT_W-1:0];
			inh_out_q <= inh_ext[INHERIT_W-1:0];
			st_out_q  <= status_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign column_index      = col_out_q;
	assign row_index         = row_out_q;
	assign column_count      = cnt_out_q;
	assign inherited_columns = inh_out_q;
	assign status            = st_out_q;

endmodule

`default_nettype wire

// ----- design/table_cell_grid_placer.sv -----
// table_cell_grid_placer: top level of the first-fit column grid placer.
// Depends on tcgp_pkg and tcgp_ctrl (which holds tcgp_ram and tcgp_run_unit).
//
//   channel | direction | handshake            | beat fields
//   --------+-----------+----------------------+-------------------------------------------
//   item    | in        | in_valid / in_ready  | opcode, column_span, row_span
//   result  | out       | out_valid / out_ready| column_index, row_index, column_count,
//           |           |                      | inherited_columns, status
//
// A start-row beat passes through S_INH and S_DONE, and its out_valid rises at the same edge
// at which in_ready returns. A place beat passes through S_LOAD, then S_SCAN, where the single
// shift-and-compare unit tries start columns in turn (the last try being the one that runs off
// the grid when there is no room), then S_MARK for the read-modify-write pass over the row window
// RAM when the cell lands, then S_DONE.
// Reset clears the control state and the per-row valid bits at once; no
// clearing pass is run. in_ready is high only while the sequencer idles;
// a result that waits for out_ready holds the next result in the sequencer.
`default_nettype none

module table_cell_grid_placer
	import tcgp_pkg::*;
#(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int ROW_WINDOW  = ROW_WINDOW_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [OPCODE_W-1:0]  opcode,
	input  wire logic [CSPAN_W-1:0]   column_span,
	input  wire logic [RSPAN_W-1:0]   row_span,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [COLIDX_W-1:0]  column_index,
	output logic      [ROWIDX_W-1:0]  row_index,
	output logic      [COLCNT_W-1:0]  column_count,
	output logic      [INHERIT_W-1:0] inherited_columns,
	output logic      [STATUS_W-1:0]  status
);

	// sequencer, window RAM and run unit live in the controller
	tcgp_ctrl #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.ROW_WINDOW (ROW_WINDOW)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.opcode           (opcode),
		.column_span      (column_span),
		.row_span         (row_span),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.column_index     (column_index),
		.row_index        (row_index),
		.column_count     (column_count),
		.inherited_columns(inherited_columns),
		.status           (status)
	);

	// hold a waiting result beat steady until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable({column_index, row_index,
		column_count, inherited_columns, status})))
		else $error("result beat changed while waiting");

	// a cell with no room is reported at column zero
	a_no_room_col: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_NO_ROOM) |-> (column_index == '0))
		else $error("no-room result carries a column");

	// only the defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_NO_ROOM || status == ST_CLAMPED))
		else $error("undefined status code");

	// handshake outputs are always known out of reset
	a_known_hs: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_ready, out_valid}))
		else $error("handshake output unknown");

endmodule

`default_nettype wire
